[hdl/bfpb_pkg.sv]
`timescale 1ns / 1ps

package bfpb_pkg;

  // Opcodes on the command channel; code 3 is ignored.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_PEEK  = 2'd2;

  localparam logic [3:0] MAX_BITS = 4'd8;

  typedef enum logic [1:0] {
    KIND_NOP,
    KIND_WRITE,
    KIND_READ,
    KIND_PEEK
  } kind_t;

  // Where a window byte lives: even bank, odd bank, or the byte-zero register.
  typedef enum logic [1:0] {
    SRC_E,
    SRC_O,
    SRC_Z
  } src_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] nbits;
    logic [2:0] shift;
    logic [7:0] data;
    src_t       lo_sel;
    src_t       hi_sel;
  } cmd_t;

endpackage

[hdl/bfpb_in_if.sv]
`timescale 1ns / 1ps

interface bfpb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [3:0] width;
  logic [7:0] data;

  modport source (output valid, op, width, data, input ready);
  modport sink (input valid, op, width, data, output ready);
endinterface

[hdl/bfpb_out_if.sv]
`timescale 1ns / 1ps

interface bfpb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_value;

  modport source (output valid, read_value, input ready);
  modport sink (input valid, read_value, output ready);
endinterface

[hdl/bfpb_front.sv]
`timescale 1ns / 1ps

module bfpb_front #(
  parameter int BUF_BYTES = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  bfpb_in_if.sink                     cmd,
  output logic                        q_push,
  input  logic                        q_ready,
  output bfpb_pkg::cmd_t              q_cmd,
  output logic [$clog2(BUF_BYTES)-2:0] q_ea,
  output logic [$clog2(BUF_BYTES)-2:0] q_oa
);

  localparam int LW = $clog2(BUF_BYTES);
  localparam int PW = LW + 3;
  localparam logic [PW:0]   SPAN = (PW+1)'(BUF_BYTES * 8);
  localparam logic [LW-1:0] LAST = LW'(BUF_BYTES - 1);

  logic [PW-1:0] wr_pos;
  logic [PW-1:0] rd_pos;
  logic [PW-1:0] pos;
  logic [PW-1:0] pos_next;
  logic [PW:0]   step;
  logic [3:0]    nbits;
  logic [LW-1:0] lo;
  logic [LW-1:0] hi;
  logic          accept;
  bfpb_pkg::kind_t kind;

  function automatic bfpb_pkg::src_t sel_of(input logic [LW-1:0] b);
    if (b == '0) begin
      return bfpb_pkg::SRC_Z;
    end
    return b[0] ? bfpb_pkg::SRC_O : bfpb_pkg::SRC_E;
  endfunction

  always_comb begin
    nbits = (cmd.width > bfpb_pkg::MAX_BITS) ? bfpb_pkg::MAX_BITS : cmd.width;
    case (cmd.op)
      bfpb_pkg::OP_WRITE: kind = bfpb_pkg::KIND_WRITE;
      bfpb_pkg::OP_READ:  kind = bfpb_pkg::KIND_READ;
      bfpb_pkg::OP_PEEK:  kind = bfpb_pkg::KIND_PEEK;
      default:            kind = bfpb_pkg::KIND_NOP;
    endcase
    if (nbits == 4'd0) begin
      kind = bfpb_pkg::KIND_NOP;
    end

    pos = (kind == bfpb_pkg::KIND_WRITE) ? wr_pos : rd_pos;
    lo  = pos[PW-1:3];
    hi  = (lo == LAST) ? '0 : lo + 1'b1;

    // wrap: step stays below twice the span
    step     = {1'b0, pos} + (PW+1)'(nbits);
    pos_next = (step >= SPAN) ? PW'(step - SPAN) : step[PW-1:0];

    q_cmd.kind   = kind;
    q_cmd.nbits  = nbits;
    q_cmd.shift  = pos[2:0];
    q_cmd.data   = cmd.data;
    q_cmd.lo_sel = sel_of(lo);
    q_cmd.hi_sel = sel_of(hi);
    // adjacent bytes always fall in opposite banks
    q_ea = lo[0] ? hi[LW-1:1] : lo[LW-1:1];
    q_oa = lo[0] ? lo[LW-1:1] : hi[LW-1:1];
  end

  assign q_push    = cmd.valid;
  assign cmd.ready = q_ready;
  assign accept    = cmd.valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos <= '0;
      rd_pos <= '0;
    end else if (accept) begin
      if (kind == bfpb_pkg::KIND_WRITE) begin
        wr_pos <= pos_next;
      end
      if (kind == bfpb_pkg::KIND_READ) begin
        rd_pos <= pos_next;
      end
    end
  end

endmodule

[hdl/bfpb_queue.sv]
`timescale 1ns / 1ps

module bfpb_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic [W-1:0] slots [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;
  logic         push;
  logic         pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slots[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= in_data;
    end
  end

endmodule

[hdl/bfpb_back.sv]
`timescale 1ns / 1ps

module bfpb_back #(
  parameter int BUF_BYTES = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  bfpb_pkg::cmd_t               q_cmd,
  input  logic [$clog2(BUF_BYTES)-2:0] q_ea,
  input  logic [$clog2(BUF_BYTES)-2:0] q_oa,
  bfpb_out_if.source                   rsp
);

  localparam int AW    = $clog2(BUF_BYTES) - 1;
  localparam int DEPTH = (BUF_BYTES + 1) / 2;

  // byte 0 lives in its own register; the banks never use it
  logic [7:0] mem_e [DEPTH];
  logic [7:0] mem_o [DEPTH];
  logic [7:0] rd_e;
  logic [7:0] rd_o;
  logic [7:0] byte0;

  logic           s2_valid;
  bfpb_pkg::cmd_t s2_cmd;
  logic [AW-1:0]  s2_ea;
  logic [AW-1:0]  s2_oa;

  // last committed byte per bank, covers the read issued on the same edge
  logic          fwd_e_v;
  logic          fwd_o_v;
  logic [AW-1:0] fwd_e_a;
  logic [AW-1:0] fwd_o_a;
  logic [7:0]    fwd_e_d;
  logic [7:0]    fwd_o_d;

  logic       out_valid;
  logic [7:0] out_val;

  logic        adv2;
  logic        load2;
  logic        pop;
  logic [7:0]  fe;
  logic [7:0]  fo;
  logic [7:0]  lo_b;
  logic [7:0]  hi_b;
  logic [15:0] win;
  logic [15:0] win_new;
  logic [15:0] mask;
  logic [7:0]  fmask;
  logic [7:0]  extract;
  logic [7:0]  result;
  logic        is_wr;
  logic        we_e;
  logic        we_o;
  logic        we_z;
  logic [7:0]  new_e;
  logic [7:0]  new_o;
  logic [7:0]  new_z;

  function automatic logic [7:0] pick(input bfpb_pkg::src_t s, input logic [7:0] e,
                                      input logic [7:0] o, input logic [7:0] z);
    case (s)
      bfpb_pkg::SRC_E: return e;
      bfpb_pkg::SRC_O: return o;
      bfpb_pkg::SRC_Z: return z;
      default:         return z;
    endcase
  endfunction

  assign adv2    = s2_valid && (!out_valid || rsp.ready);
  assign load2   = !s2_valid || adv2;
  assign q_ready = load2;
  assign pop     = q_valid && load2;

  always_comb begin
    fe   = (fwd_e_v && (fwd_e_a == s2_ea)) ? fwd_e_d : rd_e;
    fo   = (fwd_o_v && (fwd_o_a == s2_oa)) ? fwd_o_d : rd_o;
    lo_b = pick(s2_cmd.lo_sel, fe, fo, byte0);
    hi_b = pick(s2_cmd.hi_sel, fe, fo, byte0);
    win  = {hi_b, lo_b};

    fmask   = 8'((9'd1 << s2_cmd.nbits) - 9'd1);
    mask    = {8'h00, fmask} << s2_cmd.shift;
    win_new = (win & ~mask) | (({8'h00, s2_cmd.data} << s2_cmd.shift) & mask);
    extract = 8'(win >> s2_cmd.shift) & fmask;

    is_wr = (s2_cmd.kind == bfpb_pkg::KIND_WRITE);
    we_e  = is_wr && (s2_cmd.lo_sel == bfpb_pkg::SRC_E || s2_cmd.hi_sel == bfpb_pkg::SRC_E);
    we_o  = is_wr && (s2_cmd.lo_sel == bfpb_pkg::SRC_O || s2_cmd.hi_sel == bfpb_pkg::SRC_O);
    we_z  = is_wr && (s2_cmd.lo_sel == bfpb_pkg::SRC_Z || s2_cmd.hi_sel == bfpb_pkg::SRC_Z);
    new_e = (s2_cmd.lo_sel == bfpb_pkg::SRC_E) ? win_new[7:0] : win_new[15:8];
    new_o = (s2_cmd.lo_sel == bfpb_pkg::SRC_O) ? win_new[7:0] : win_new[15:8];
    new_z = (s2_cmd.lo_sel == bfpb_pkg::SRC_Z) ? win_new[7:0] : win_new[15:8];

    result = (s2_cmd.kind == bfpb_pkg::KIND_READ || s2_cmd.kind == bfpb_pkg::KIND_PEEK)
             ? extract : 8'h00;
  end

  // banks: read on pop, write on commit (read returns the old byte)
  always_ff @(posedge clk) begin
    if (pop) begin
      rd_e <= mem_e[q_ea];
      rd_o <= mem_o[q_oa];
    end
    if (adv2 && we_e) begin
      mem_e[s2_ea] <= new_e;
    end
    if (adv2 && we_o) begin
      mem_o[s2_oa] <= new_o;
    end
  end

  always_ff @(posedge clk) begin
    if (load2) begin
      s2_cmd <= q_cmd;
      s2_ea  <= q_ea;
      s2_oa  <= q_oa;
    end
    if (adv2) begin
      out_val <= result;
      if (we_z) begin
        byte0 <= new_z;
      end
      if (we_e) begin
        fwd_e_a <= s2_ea;
        fwd_e_d <= new_e;
      end
      if (we_o) begin
        fwd_o_a <= s2_oa;
        fwd_o_d <= new_o;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
      fwd_e_v   <= 1'b0;
      fwd_o_v   <= 1'b0;
    end else begin
      if (load2) begin
        s2_valid <= q_valid;
      end
      if (adv2) begin
        out_valid <= 1'b1;
        if (we_e) begin
          fwd_e_v <= 1'b1;
        end
        if (we_o) begin
          fwd_o_v <= 1'b1;
        end
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_val;

endmodule

[hdl/bit_field_pack_unpack_buffer_core.sv]
`timescale 1ns / 1ps
// Channel | Dir | Payload                       | Item
// cmd     | in  | op[1:0] width[3:0] data[7:0]  | one write/read/peek request
// rsp     | out | read_value[7:0]               | one result per request
//
// One item per cycle sustained while rsp is not stalled; an accepted item passes
// the queue, bank read and merge into output register before rsp.valid rises.
// Even/odd byte banks give one read and one write per bank per cycle; the
// write committed on the edge of a read is forwarded.
// Synchronous reset clears both bit pointers and all pipeline valids; the
// store contents are undefined until written. A stalled rsp backs up through
// the two-entry queue before cmd.ready drops.
module bit_field_pack_unpack_buffer_core #(
  parameter int BUF_BYTES = 1024
) (
  input  logic       clk,
  input  logic       rst,
  bfpb_in_if.sink    cmd,
  bfpb_out_if.source rsp
);

  localparam int AW = $clog2(BUF_BYTES) - 1;
  localparam int QW = $bits(bfpb_pkg::cmd_t) + 2 * AW;

  logic           f_push;
  logic           f_ready;
  bfpb_pkg::cmd_t f_cmd;
  logic [AW-1:0]  f_ea;
  logic [AW-1:0]  f_oa;

  logic           b_valid;
  logic           b_ready;
  bfpb_pkg::cmd_t b_cmd;
  logic [AW-1:0]  b_ea;
  logic [AW-1:0]  b_oa;
  logic [QW-1:0]  q_out;

  // front: clamp width, classify, compute window and advance pointers
  bfpb_front #(.BUF_BYTES(BUF_BYTES)) u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .q_push  (f_push),
    .q_ready (f_ready),
    .q_cmd   (f_cmd),
    .q_ea    (f_ea),
    .q_oa    (f_oa)
  );

  // decoupling queue between front and back
  bfpb_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_push),
    .in_ready  (f_ready),
    .in_data   ({f_cmd, f_ea, f_oa}),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_data  (q_out)
  );

  assign {b_cmd, b_ea, b_oa} = q_out;

  // back: bank read, merge or extract, write back, output register
  bfpb_back #(.BUF_BYTES(BUF_BYTES)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (b_valid),
    .q_ready (b_ready),
    .q_cmd   (b_cmd),
    .q_ea    (b_ea),
    .q_oa    (b_oa),
    .rsp     (rsp)
  );

endmodule

[hdl/bfpb_check.sv]
`timescale 1ns / 1ps

module bfpb_check (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] rsp_read_value
);

  logic [2:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = cmd_valid && cmd_ready;
  assign out_acc = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 3'd0;
    end else begin
      pending <= pending + {2'b00, in_acc} - {2'b00, out_acc};
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp valid dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_read_value))
    else $error("rsp payload changed while stalled");

  a_rst_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("rsp valid right after reset");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> pending != 3'd0)
    else $error("result with no request outstanding");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd4)
    else $error("more items in flight than buffer stages");

endmodule

bind bit_field_pack_unpack_buffer_core bfpb_check u_bfpb_check (
  .clk            (clk),
  .rst            (rst),
  .cmd_valid      (cmd.valid),
  .cmd_ready      (cmd.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_read_value (rsp.read_value)
);

[test/bit_field_pack_unpack_buffer_core_checker.sv]
`timescale 1ns / 1ps

module bit_field_pack_unpack_buffer_core_checker #(
  parameter int BUF_BYTES = 1024
) (
  input  logic clk,
  input  logic rst,
  bfpb_in_if   cmd,
  bfpb_out_if  rsp,
  output int   errors,
  output int   pending
);

  localparam int SPAN = BUF_BYTES * 8;

  typedef struct {
    logic [1:0] op;
    logic [3:0] width;
    logic [7:0] data;
    logic [7:0] value;
  } bit_request_t;

  // Shadow copy of the bit store and both bit pointers.
  logic [7:0]   shadow_bytes [BUF_BYTES];
  int           wr_bit = 0;
  int           rd_bit = 0;
  int           err_cnt = 0;
  bit_request_t read_values_q [$];

  initial begin
    for (int i = 0; i < BUF_BYTES; i++) shadow_bytes[i] = 8'd0;
  end

  // Applies one request to the shadow store; returns the value it should yield.
  function automatic logic [7:0] apply_bit_request(logic [1:0] op, logic [3:0] width,
                                                   logic [7:0] data);
    int          nbits;
    int          ptr;
    int          lo;
    int          hi;
    logic [15:0] win;
    logic [15:0] mask;
    logic [7:0]  value;
    nbits = (width > bfpb_pkg::MAX_BITS) ? bfpb_pkg::MAX_BITS : width;
    value = 8'd0;
    if (nbits == 0 ||
        !(op inside {bfpb_pkg::OP_WRITE, bfpb_pkg::OP_READ, bfpb_pkg::OP_PEEK}))
      return value;
    ptr  = (op == bfpb_pkg::OP_WRITE) ? wr_bit : rd_bit;
    lo   = ptr / 8;
    hi   = (lo + 1) % BUF_BYTES;   // last byte pairs with byte zero
    win  = {shadow_bytes[hi], shadow_bytes[lo]};
    mask = ((16'd1 << nbits) - 16'd1) << (ptr % 8);
    if (op == bfpb_pkg::OP_WRITE) begin
      win = (win & ~mask) | (({8'd0, data} << (ptr % 8)) & mask);
      shadow_bytes[lo] = win[7:0];
      shadow_bytes[hi] = win[15:8];
      wr_bit = (wr_bit + nbits) % SPAN;
    end else begin
      value = 8'((win >> (ptr % 8)) & ((16'd1 << nbits) - 16'd1));
      if (op == bfpb_pkg::OP_READ) rd_bit = (rd_bit + nbits) % SPAN;
    end
    return value;
  endfunction

  always @(posedge clk) begin : watch
    bit_request_t req;
    if (rst) begin
      read_values_q.delete();
      wr_bit = 0;
      rd_bit = 0;
    end else begin
      // a result never leaves in the cycle its request is accepted, so pop first
      if (rsp.valid && rsp.ready) begin
        if (read_values_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result item: read_value %h", rsp.read_value);
        end else begin
          req = read_values_q.pop_front();
          if (rsp.read_value !== req.value) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch: op %0d width %0d data %h: read_value expected %h, got %h",
                       req.op, req.width, req.data, req.value, rsp.read_value);
          end
        end
      end
      if (cmd.valid && cmd.ready) begin
        req.op    = cmd.op;
        req.width = cmd.width;
        req.data  = cmd.data;
        req.value = apply_bit_request(cmd.op, cmd.width, cmd.data);
        read_values_q.push_back(req);
      end
    end
    errors  <= err_cnt;
    pending <= read_values_q.size();
  end

endmodule

[test/bit_field_pack_unpack_buffer_core_tb.sv]
`timescale 1ns / 1ps

module bit_field_pack_unpack_buffer_core_tb;

  localparam int BUF_BYTES   = 1024;
  localparam int SPAN        = BUF_BYTES * 8;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 120;
  // opcode the block must ignore
  localparam logic [1:0] OP_IGNORED = 2'd3;

  // idle modes, rotated through the random part
  localparam int MODE_NONE     = 0;
  localparam int MODE_SEND_IDL = 1;
  localparam int MODE_RECV_IDL = 2;
  localparam int MODE_BOTH_IDL = 3;

  logic clk;
  logic rst;
  int   errors;
  int   pending;

  bfpb_in_if  cmd_if ();
  bfpb_out_if rsp_if ();

  bit_field_pack_unpack_buffer_core #(
    .BUF_BYTES(BUF_BYTES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .rsp(rsp_if)
  );

  bit_field_pack_unpack_buffer_core_checker #(
    .BUF_BYTES(BUF_BYTES)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .rsp(rsp_if),
    .errors(errors),
    .pending(pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Traffic shaping state. idle_mode picks the gap/stall mix; a bump of
  // hold_ticket asks the receiver for one long hold-off.
  int idle_mode   = MODE_NONE;
  int hold_ticket = 0;
  int hold_served = 0;
  int hold_left   = 0;

  // Which bits have been written so far, plus the stimulus-side bit pointers.
  // Reads and peeks are only issued over written bits.
  bit written [SPAN];
  int gen_wr = 0;
  int gen_rd = 0;

  // Receiver: random stalls per mode, long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready  <= 1'b0;
    end else if (hold_served != hold_ticket) begin
      hold_served   <= hold_ticket;
      hold_left     <= HOLD_CYCLES;
      rsp_if.ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      rsp_if.ready  <= 1'b0;
    end else if (idle_mode == MODE_RECV_IDL) begin
      rsp_if.ready  <= ($urandom_range(99) >= 84);
    end else if (idle_mode == MODE_BOTH_IDL) begin
      rsp_if.ready  <= ($urandom_range(99) >= 7);
    end else begin
      rsp_if.ready  <= 1'b1;
    end
  end

  function automatic int clamp_bits(logic [3:0] width);
    return (width > bfpb_pkg::MAX_BITS) ? bfpb_pkg::MAX_BITS : width;
  endfunction

  // True when every bit the next read/peek of this width would touch is written.
  function automatic bit readable(logic [3:0] width);
    for (int i = 0; i < clamp_bits(width); i++)
      if (!written[(gen_rd + i) % SPAN]) return 1'b0;
    return 1'b1;
  endfunction

  // Advance the stimulus-side pointers for an accepted item.
  function automatic void track_item(logic [1:0] op, logic [3:0] width);
    int nbits;
    nbits = clamp_bits(width);
    if (op == bfpb_pkg::OP_WRITE) begin
      for (int i = 0; i < nbits; i++) written[(gen_wr + i) % SPAN] = 1'b1;
      gen_wr = (gen_wr + nbits) % SPAN;
    end else if (op == bfpb_pkg::OP_READ) begin
      gen_rd = (gen_rd + nbits) % SPAN;
    end
  endfunction

  // Offer one item, with sender gaps per mode; returns once it is accepted.
  task automatic send_item(logic [1:0] op, logic [3:0] width, logic [7:0] data);
    int gap_pct;
    gap_pct = (idle_mode == MODE_SEND_IDL) ? 84 : (idle_mode == MODE_BOTH_IDL) ? 7 : 0;
    while ($urandom_range(99) < gap_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.op    <= op;
    cmd_if.width <= width;
    cmd_if.data  <= data;
    do @(posedge clk); while (!cmd_if.ready);
    track_item(op, width);
  endtask

  // Mostly well-formed traffic: writes and reads balanced on the unread
  // backlog so both pointers keep moving. A few percent are corner items:
  // opcode three, zero width, widths above eight.
  task automatic send_random_item();
    int         backlog;
    int         write_pct;
    logic [1:0] op;
    logic [3:0] width;
    logic [7:0] data;
    data      = 8'($urandom_range(255));
    width     = ($urandom_range(99) < 60) ? bfpb_pkg::MAX_BITS : 4'($urandom_range(1, 8));
    backlog   = (gen_wr - gen_rd + SPAN) % SPAN;
    write_pct = (backlog < 256) ? 75 : (backlog > SPAN / 2) ? 25 : 50;
    if ($urandom_range(99) < 5) begin
      op    = 2'($urandom_range(3));
      width = 4'($urandom_range(15));
    end else if ($urandom_range(99) < write_pct) begin
      op = bfpb_pkg::OP_WRITE;
    end else begin
      op = ($urandom_range(3) == 0) ? bfpb_pkg::OP_PEEK : bfpb_pkg::OP_READ;
    end
    // never extract unwritten bits; turn such a request into a write
    if ((op == bfpb_pkg::OP_READ || op == bfpb_pkg::OP_PEEK) && !readable(width))
      op = bfpb_pkg::OP_WRITE;
    send_item(op, width, data);
  endtask

  initial begin : stimulus
    int sent;
    rst          <= 1'b1;
    cmd_if.valid <= 1'b0;
    cmd_if.op    <= bfpb_pkg::OP_WRITE;
    cmd_if.width <= 4'd0;
    cmd_if.data  <= 8'd0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, every opcode, zero width, oversized width,
    // ignored opcode, windows that straddle a byte boundary.
    send_item(bfpb_pkg::OP_WRITE, 4'd8,  8'hFF);  // bits 0..7
    send_item(bfpb_pkg::OP_WRITE, 4'd1,  8'h00);  // bit 8
    send_item(bfpb_pkg::OP_WRITE, 4'd3,  8'hFD);  // bits 9..11, only low 3 bits land
    send_item(bfpb_pkg::OP_WRITE, 4'd0,  8'hFF);  // zero width: no effect
    send_item(bfpb_pkg::OP_WRITE, 4'd15, 8'h5A);  // saturates to 8, bits 12..19 straddle
    send_item(OP_IGNORED,         4'd8,  8'hFF);  // ignored opcode
    send_item(bfpb_pkg::OP_WRITE, 4'd8,  8'h00);  // bits 20..27
    send_item(bfpb_pkg::OP_WRITE, 4'd8,  8'hFF);  // bits 28..35
    send_item(bfpb_pkg::OP_PEEK,  4'd8,  8'h00);  // peek does not move the pointer
    send_item(bfpb_pkg::OP_READ,  4'd1,  8'hFF);
    send_item(bfpb_pkg::OP_READ,  4'd8,  8'h00);  // unaligned full byte
    send_item(bfpb_pkg::OP_PEEK,  4'd0,  8'h00);
    send_item(bfpb_pkg::OP_READ,  4'd0,  8'hFF);
    send_item(bfpb_pkg::OP_READ,  4'd12, 8'h00);  // saturates to 8
    send_item(bfpb_pkg::OP_READ,  4'd2,  8'h00);
    send_item(bfpb_pkg::OP_READ,  4'd8,  8'h00);
    send_item(bfpb_pkg::OP_PEEK,  4'd8,  8'h00);
    send_item(bfpb_pkg::OP_READ,  4'd7,  8'h00);
    send_item(OP_IGNORED,         4'd0,  8'h00);
    send_item(bfpb_pkg::OP_WRITE, 4'd4,  8'hF0);  // upper data bits dropped
    send_item(bfpb_pkg::OP_READ,  4'd6,  8'h00);
    send_item(bfpb_pkg::OP_WRITE, 4'd8,  8'h3C);
    send_item(bfpb_pkg::OP_PEEK,  4'd15, 8'h00);
    send_item(bfpb_pkg::OP_READ,  4'd8,  8'h00);

    // Random part opens with a long receiver hold-off while items keep
    // coming, so the queue fills and cmd.ready drops.
    hold_ticket <= hold_ticket + 1;
    sent = 0;
    while (sent < 1500) begin
      if (sent % 250 == 0) idle_mode <= (sent / 250) % 4;
      if (sent == 1000) begin
        // drain completely before carrying on
        cmd_if.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      send_random_item();
      sent++;
    end

    cmd_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    // pipeline is 3 deep; leave room for any stray result
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

endmodule
